// ===== rtl/core/lfpw_pkg.sv =====
// ----------------------------------------------------------------------------
// lfpw_pkg
// Shared types and constants of the lf pulse width frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lfpw_pkg;

  // decoder phases; codes 6 and 7 are unused and force a back-off
  typedef enum logic [2:0] {
    PH_PRE_RISE = 3'd0,
    PH_PRE_FALL = 3'd1,
    PH_GAP      = 3'd2,
    PH_START    = 3'd3,
    PH_DATA     = 3'd4,
    PH_SKIP     = 3'd5
  } phase_t;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CRC_ERR  = 2'd1;
  localparam logic [1:0] ST_PRE_REJ  = 2'd2;
  localparam logic [1:0] ST_ERR_LIM  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_PREAMBLE_MIN = 3'd0;
  localparam logic [2:0] REG_PREAMBLE_MAX = 3'd1;
  localparam logic [2:0] REG_GAP_MIN      = 3'd2;
  localparam logic [2:0] REG_GAP_MAX      = 3'd3;
  localparam logic [2:0] REG_ZERO_MIN     = 3'd4;
  localparam logic [2:0] REG_ZERO_MAX     = 3'd5;
  localparam logic [2:0] REG_ONE_MIN      = 3'd6;
  localparam logic [2:0] REG_ONE_MAX      = 3'd7;

  localparam logic [4:0]  FRAME_BITS    = 5'd24;
  localparam logic [4:0]  CRC_STOP_LEFT = 5'd6;
  localparam logic [2:0]  ERR_LIMIT     = 3'd5;
  localparam logic [2:0]  ERR_SAT       = 3'd7;
  localparam logic [7:0]  CRC_POLY      = 8'h20;
  localparam logic [7:0]  CRC_TOP       = 8'h80;
  localparam logic [31:0] SHORT_BACKOFF = 32'd4920;
  localparam logic [31:0] LIMIT_BACKOFF = 32'd32768;
  localparam logic [31:0] GOOD_BACKOFF  = 32'd49152;

  typedef struct packed {
    logic [7:0] preamble_min;
    logic [7:0] preamble_max;
    logic [7:0] gap_min;
    logic [7:0] gap_max;
    logic [7:0] zero_min;
    logic [7:0] zero_max;
    logic [7:0] one_min;
    logic [7:0] one_max;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic        backing_off;
    logic [31:0] deadline;
    logic [31:0] last_time;
    logic [23:0] shift_buf;
    logic [4:0]  bits_left;
    logic [7:0]  crc;
    logic [2:0]  err_count;
  } dec_state_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  status;
    logic [10:0] tag_id;
    logic [5:0]  command;
  } dec_result_t;

  // exclusive window check of a 32-bit width against 8-bit bounds
  function automatic logic in_window(logic [31:0] w, logic [7:0] lo, logic [7:0] hi);
    return (w > {24'd0, lo}) && (w < {24'd0, hi});
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lfpw_step.sv =====
// ----------------------------------------------------------------------------
// lfpw_step
// Next-state and result logic for one edge of the frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpw_step (
  input  wire lfpw_pkg::cfg_t       cfg,
  input  wire lfpw_pkg::dec_state_t st,
  input  wire logic [31:0]          edge_time,
  input  wire logic                 edge_rising,
  output lfpw_pkg::dec_state_t      st_next,
  output lfpw_pkg::dec_result_t     res
);

  always_comb begin
    logic        go;
    logic [31:0] since_deadline;
    logic [31:0] diff;
    logic [31:0] width;
    logic        bit_val;
    logic        bit_ok;
    logic [23:0] shift_new;
    logic [4:0]  left_new;

    st_next        = st;
    res            = '0;
    go             = 1'b1;
    since_deadline = edge_time - st.deadline;
    diff           = edge_time - st.last_time;
    width          = diff[31] ? (32'd0 - diff) : diff;
    bit_val        = 1'b0;
    bit_ok         = 1'b0;
    shift_new      = '0;
    left_new       = '0;

    // back-off: drop edges until the deadline is reached
    if (st.backing_off) begin
      if (since_deadline[31]) begin
        go = 1'b0;
      end else begin
        st_next.backing_off = 1'b0;
        st_next.phase       = lfpw_pkg::PH_PRE_RISE;
      end
    end

    // polarity filter in the preamble phases
    if (go && st_next.phase == lfpw_pkg::PH_PRE_RISE && !edge_rising) go = 1'b0;
    if (go && st_next.phase == lfpw_pkg::PH_PRE_FALL && edge_rising) go = 1'b0;

    if (go) begin
      st_next.last_time = edge_time;
      if (st.err_count > lfpw_pkg::ERR_LIMIT) begin
        st_next.err_count   = '0;
        st_next.backing_off = 1'b1;
        st_next.deadline    = edge_time + lfpw_pkg::LIMIT_BACKOFF;
        st_next.phase       = lfpw_pkg::PH_PRE_RISE;
        res.valid           = 1'b1;
        res.status          = lfpw_pkg::ST_ERR_LIM;
      end else begin
        unique case (st_next.phase)
          lfpw_pkg::PH_SKIP, lfpw_pkg::PH_START: begin
            st_next.phase = lfpw_pkg::PH_DATA;
          end
          lfpw_pkg::PH_PRE_RISE: begin
            st_next.phase = lfpw_pkg::PH_PRE_FALL;
          end
          lfpw_pkg::PH_PRE_FALL: begin
            if (lfpw_pkg::in_window(width, cfg.preamble_min, cfg.preamble_max)) begin
              st_next.phase     = lfpw_pkg::PH_GAP;
              st_next.shift_buf = '0;
              st_next.bits_left = lfpw_pkg::FRAME_BITS;
              st_next.crc       = '0;
            end else begin
              if (st.err_count != lfpw_pkg::ERR_SAT) st_next.err_count = st.err_count + 3'd1;
              st_next.backing_off = 1'b1;
              st_next.deadline    = edge_time + lfpw_pkg::SHORT_BACKOFF;
              st_next.phase       = lfpw_pkg::PH_PRE_RISE;
              res.valid           = 1'b1;
              res.status          = lfpw_pkg::ST_PRE_REJ;
            end
          end
          lfpw_pkg::PH_GAP: begin
            if (lfpw_pkg::in_window(width, cfg.gap_min, cfg.gap_max)) begin
              st_next.phase = lfpw_pkg::PH_START;
            end else if (st.err_count != lfpw_pkg::ERR_SAT) begin
              st_next.err_count = st.err_count + 3'd1;
            end
          end
          lfpw_pkg::PH_DATA: begin
            if (lfpw_pkg::in_window(width, cfg.zero_min, cfg.zero_max)) begin
              bit_ok        = 1'b1;
              bit_val       = 1'b0;
              st_next.phase = lfpw_pkg::PH_SKIP;
            end else if (lfpw_pkg::in_window(width, cfg.one_min, cfg.one_max)) begin
              bit_ok  = 1'b1;
              bit_val = 1'b1;
            end else if (st.err_count != lfpw_pkg::ERR_SAT) begin
              st_next.err_count = st.err_count + 3'd1;
            end
            if (bit_ok) begin
              shift_new         = {st.shift_buf[22:0], bit_val};
              left_new          = st.bits_left - 5'd1;
              st_next.shift_buf = shift_new;
              st_next.bits_left = left_new;
              if (left_new > lfpw_pkg::CRC_STOP_LEFT) begin
                // serial crc step
                if (st.crc[1] ^ bit_val)
                  st_next.crc = ((st.crc ^ lfpw_pkg::CRC_POLY) >> 1) | lfpw_pkg::CRC_TOP;
                else
                  st_next.crc = st.crc >> 1;
              end else if (left_new == 5'd0) begin
                st_next.backing_off = 1'b1;
                st_next.phase       = lfpw_pkg::PH_PRE_RISE;
                res.valid           = 1'b1;
                if (st.crc[7:1] == shift_new[6:0]) begin
                  st_next.err_count = '0;
                  st_next.deadline  = edge_time + lfpw_pkg::GOOD_BACKOFF;
                  res.status        = lfpw_pkg::ST_OK;
                  res.tag_id        = shift_new[23:13];
                  res.command       = shift_new[12:7];
                end else begin
                  st_next.deadline  = edge_time + lfpw_pkg::SHORT_BACKOFF;
                  res.status        = lfpw_pkg::ST_CRC_ERR;
                end
              end
            end
          end
          default: begin
            st_next.backing_off = 1'b1;
            st_next.deadline    = edge_time + lfpw_pkg::SHORT_BACKOFF;
            st_next.phase       = lfpw_pkg::PH_PRE_RISE;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lf_pulse_width_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// lf_pulse_width_frame_decoder
// Decodes pulse width coded frames from timestamped lf edges.
// ----------------------------------------------------------------------------
// channel | dir | tdata                          | tuser
// s_axis  | in  | [31:0] edge_time               | [0] edge_rising
// m_axis  | out | [10:0] tag_id, [16:11] command | [1:0] status
// cfg     | in  | cfg_wdata[7:0] to register cfg_addr when cfg_we is high
//
// one edge word per cycle while no held result stalls the decode step; an edge is
// registered in the input register and its result, if any, in the output register
// the decode step is a single pass: two 32-bit subtracts and an abs, 8-bit window
// compares, a shift and a crc step; state feeds back into the next edge
// rst (synchronous) returns the valid flags, configuration and decoder state to defaults
// a pending result stalls the decode step until m_tready takes it
// ----------------------------------------------------------------------------
`default_nettype none

module lf_pulse_width_frame_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  // edge words
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] edge_time
  input  wire logic        s_tuser,   // [0] edge_rising
  // result words
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [10:0] tag_id, [16:11] command, rest zero
  output logic [1:0]       m_tuser,   // [1:0] status
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [7:0]  cfg_wdata
);

  lfpw_pkg::cfg_t        cfg;
  lfpw_pkg::dec_state_t  st;
  lfpw_pkg::dec_state_t  st_next;
  lfpw_pkg::dec_result_t res;

  // input register
  logic        in_valid;
  logic [31:0] in_time;
  logic        in_rising;

  logic out_free;
  logic step_fire;

  assign out_free  = !m_tvalid || m_tready;
  assign step_fire = in_valid && out_free;
  assign s_tready  = !in_valid || out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preamble_min <= 8'd49;
      cfg.preamble_max <= 8'd200;
      cfg.gap_min      <= 8'd41;
      cfg.gap_max      <= 8'd45;
      cfg.zero_min     <= 8'd5;
      cfg.zero_max     <= 8'd11;
      cfg.one_min      <= 8'd13;
      cfg.one_max      <= 8'd22;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lfpw_pkg::REG_PREAMBLE_MIN: cfg.preamble_min <= cfg_wdata;
        lfpw_pkg::REG_PREAMBLE_MAX: cfg.preamble_max <= cfg_wdata;
        lfpw_pkg::REG_GAP_MIN:      cfg.gap_min      <= cfg_wdata;
        lfpw_pkg::REG_GAP_MAX:      cfg.gap_max      <= cfg_wdata;
        lfpw_pkg::REG_ZERO_MIN:     cfg.zero_min     <= cfg_wdata;
        lfpw_pkg::REG_ZERO_MAX:     cfg.zero_max     <= cfg_wdata;
        lfpw_pkg::REG_ONE_MIN:      cfg.one_min      <= cfg_wdata;
        lfpw_pkg::REG_ONE_MAX:      cfg.one_max      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register: refills in the same cycle it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step_fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_time   <= s_tdata;
      in_rising <= s_tuser;
    end
  end

  // decode step
  lfpw_step u_step (
    .cfg         (cfg),
    .st          (st),
    .edge_time   (in_time),
    .edge_rising (in_rising),
    .st_next     (st_next),
    .res         (res)
  );

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase       <= lfpw_pkg::PH_PRE_RISE;
      st.backing_off <= 1'b0;
      st.deadline    <= '0;
      st.last_time   <= '0;
      st.shift_buf   <= '0;
      st.bits_left   <= '0;
      st.crc         <= '0;
      st.err_count   <= '0;
    end else if (step_fire) begin
      st <= st_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step_fire && res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && res.valid) begin
      m_tdata <= {7'd0, res.command, res.tag_id};
      m_tuser <= res.status;
    end
  end

`ifndef ASSERT_OFF
  // only a good frame carries id and command
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != lfpw_pkg::ST_OK) |-> (m_tdata == 24'd0))
    else $error("nonzero payload on a failed result");

  // every result starts a back-off from the preamble phase
  a_result_backoff: assert property (@(posedge clk) disable iff (rst)
    (step_fire && res.valid) |=> (st.backing_off && st.phase == lfpw_pkg::PH_PRE_RISE))
    else $error("result without back-off");

  // frame phases always have bits left to collect
  a_bits_left: assert property (@(posedge clk) disable iff (rst)
    (st.phase == lfpw_pkg::PH_GAP || st.phase == lfpw_pkg::PH_START ||
     st.phase == lfpw_pkg::PH_DATA || st.phase == lfpw_pkg::PH_SKIP)
    |-> (st.bits_left != 5'd0 && st.bits_left <= lfpw_pkg::FRAME_BITS))
    else $error("bit counter out of range in frame phase");

  // a held result is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !step_fire)
    else $error("decode step while result is held");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/lfpw_frame_scoreboard.sv =====
// ----------------------------------------------------------------------------
// lfpw_frame_scoreboard
// Bit-exact prediction of decoder results and in-order checking of the
// result words that leave the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfpw_tb_pkg;

  import lfpw_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] tag_id;
    logic [5:0]  command;
  } frame_report_t;

  class frame_scoreboard;
    cfg_t            cfg;
    phase_t          phase;
    bit              backing_off;
    logic [31:0]     deadline;
    logic [31:0]     last_time;
    logic [23:0]     shift_buf;
    logic [4:0]      bits_left;
    logic [7:0]      crc;
    logic [2:0]      err_count;
    frame_report_t   reports_due[$];
    int unsigned     n_edges;
    int unsigned     n_live;
    int unsigned     n_reports;
    int unsigned     n_errors;
    int unsigned     status_seen[4];

    function new();
      cfg         = '{8'd49, 8'd200, 8'd41, 8'd45, 8'd5, 8'd11, 8'd13, 8'd22};
      phase       = PH_PRE_RISE;
      backing_off = 1'b0;
      deadline    = '0;
      last_time   = '0;
      shift_buf   = '0;
      bits_left   = '0;
      crc         = '0;
      err_count   = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] v);
      case (idx)
        REG_PREAMBLE_MIN: cfg.preamble_min = v;
        REG_PREAMBLE_MAX: cfg.preamble_max = v;
        REG_GAP_MIN:      cfg.gap_min = v;
        REG_GAP_MAX:      cfg.gap_max = v;
        REG_ZERO_MIN:     cfg.zero_min = v;
        REG_ZERO_MAX:     cfg.zero_max = v;
        REG_ONE_MIN:      cfg.one_min = v;
        REG_ONE_MAX:      cfg.one_max = v;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return reports_due.size();
    endfunction

    // bounds are exclusive on both sides
    function bit strictly_between(logic [31:0] w, logic [7:0] lo, logic [7:0] hi);
      return (w > {24'd0, lo}) && (w < {24'd0, hi});
    endfunction

    function void start_backoff(logic [31:0] now, logic [31:0] ticks);
      backing_off = 1'b1;
      deadline    = now + ticks;
      phase       = PH_PRE_RISE;
    endfunction

    function void bump_errors();
      if (err_count < ERR_SAT) err_count++;
    endfunction

    function void post_report(logic [1:0] st, logic [10:0] id, logic [5:0] cmd);
      frame_report_t r;
      r.status  = st;
      r.tag_id  = id;
      r.command = cmd;
      reports_due.push_back(r);
    endfunction

    // one accepted edge word
    function void note_edge(logic [31:0] now, logic rising);
      logic [31:0] diff;
      logic [31:0] width;
      logic        bit_val;
      n_edges++;
      if (backing_off) begin
        diff = now - deadline;
        if (diff[31]) return;
        backing_off = 1'b0;
        phase = PH_PRE_RISE;
      end
      if (phase == PH_PRE_RISE && !rising) return;
      if (phase == PH_PRE_FALL && rising) return;
      n_live++;
      diff      = now - last_time;
      width     = diff[31] ? (32'd0 - diff) : diff;
      last_time = now;
      if (err_count > ERR_LIMIT) begin
        err_count = '0;
        start_backoff(now, LIMIT_BACKOFF);
        post_report(ST_ERR_LIM, '0, '0);
        return;
      end
      case (phase)
        PH_SKIP, PH_START: phase = PH_DATA;
        PH_PRE_RISE: phase = PH_PRE_FALL;
        PH_PRE_FALL: begin
          if (strictly_between(width, cfg.preamble_min, cfg.preamble_max)) begin
            phase     = PH_GAP;
            shift_buf = '0;
            bits_left = FRAME_BITS;
            crc       = '0;
          end else begin
            bump_errors();
            start_backoff(now, SHORT_BACKOFF);
            post_report(ST_PRE_REJ, '0, '0);
          end
        end
        PH_GAP: begin
          if (strictly_between(width, cfg.gap_min, cfg.gap_max)) phase = PH_START;
          else bump_errors();
        end
        PH_DATA: begin
          if (strictly_between(width, cfg.zero_min, cfg.zero_max)) begin
            bit_val = 1'b0;
            phase   = PH_SKIP;
          end else if (strictly_between(width, cfg.one_min, cfg.one_max)) begin
            bit_val = 1'b1;
          end else begin
            bump_errors();
            return;
          end
          shift_buf = {shift_buf[22:0], bit_val};
          bits_left = bits_left - 5'd1;
          if (bits_left > CRC_STOP_LEFT) begin
            if (crc[1] ^ bit_val) crc = ((crc ^ CRC_POLY) >> 1) | CRC_TOP;
            else crc = crc >> 1;
            return;
          end
          if (bits_left != 5'd0) return;
          if (crc[7:1] == shift_buf[6:0]) begin
            err_count = '0;
            start_backoff(now, GOOD_BACKOFF);
            post_report(ST_OK, shift_buf[23:13], shift_buf[12:7]);
          end else begin
            start_backoff(now, SHORT_BACKOFF);
            post_report(ST_CRC_ERR, '0, '0);
          end
        end
        default: start_backoff(now, SHORT_BACKOFF);
      endcase
    endfunction

    function void check_report(logic [1:0] st, logic [10:0] id, logic [5:0] cmd);
      frame_report_t want;
      if (reports_due.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected result word: status %0d tag %0h cmd %0h", st, id, cmd);
        return;
      end
      want = reports_due.pop_front();
      n_reports++;
      if (!$isunknown(st)) status_seen[st]++;
      if (want.status !== st || want.tag_id !== id || want.command !== cmd) begin
        n_errors++;
        if (n_errors <= 10)
          $display("result %0d mismatch: expected status %0d tag %0h cmd %0h, got %0d %0h %0h",
                   n_reports, want.status, want.tag_id, want.command, st, id, cmd);
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives timestamped edge words into the lf pulse width frame decoder:
// boundary cases first, then well-formed frames with random content mixed
// with damaged frames and noise, over several register settings. Every result
// word is checked against an in-order prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  import lfpw_pkg::*;
  import lfpw_tb_pkg::*;

  typedef enum int {
    FL_CLEAN,
    FL_BAD_PREAMBLE,
    FL_BAD_GAP,
    FL_STRAY,
    FL_CRC,
    FL_CUT,
    FL_POLARITY
  } frame_flaw_t;

  localparam int unsigned HOLD_CYCLES = 600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;     // [31:0] edge_time
  logic        s_tuser = 1'b0;   // [0] edge_rising
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;          // [10:0] tag_id, [16:11] command
  logic [1:0]  m_tuser;          // [1:0] status
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [7:0]  cfg_wdata = '0;

  frame_scoreboard sb = new();

  // steady turns off idling on both sides for a while
  bit steady = 1'b0;
  // one long receiver hold-off, requested by the stimulus
  bit hold_req = 1'b0;

  lf_pulse_width_frame_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // a width that lands inside an exclusive window, edges of the window favored
  function automatic int unsigned hit_width(logic [7:0] lo, logic [7:0] hi);
    int unsigned l;
    int unsigned h;
    l = {24'd0, lo};
    h = {24'd0, hi};
    if (h <= l + 1) return l + 1;
    case ($urandom_range(0, 7))
      0: return l + 1;
      1: return h - 1;
      default: return $urandom_range(l + 1, h - 1);
    endcase
  endfunction

  // a width that misses the window: zero, either bound, or far too long
  function automatic int unsigned miss_width(logic [7:0] lo, logic [7:0] hi);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return {24'd0, lo};
      2: return {24'd0, hi};
      default: return 255 + $urandom_range(0, 600);
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // edge words: called at a falling edge, returns at the falling edge after
  // acceptance with tvalid still high so back-to-back words stay gapless
  // ------------------------------------------------------------------------
  task automatic send_edge(logic [31:0] t, logic rising);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= t;
    s_tuser  <= rising;
    do @(posedge clk); while (!s_tready);
    sb.note_edge(t, rising);
    @(negedge clk);
  endtask

  // drop tvalid and wait until the decoder has nothing left in flight
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // an edge with no result may still sit in the input register
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  // write all eight registers back to back; only called while idle
  task automatic load_cfg(cfg_t c);
    logic [2:0] idx[8];
    logic [7:0] vals[8];
    idx  = '{REG_PREAMBLE_MIN, REG_PREAMBLE_MAX, REG_GAP_MIN, REG_GAP_MAX,
             REG_ZERO_MIN, REG_ZERO_MAX, REG_ONE_MIN, REG_ONE_MAX};
    vals = '{c.preamble_min, c.preamble_max, c.gap_min, c.gap_max,
             c.zero_min, c.zero_max, c.one_min, c.one_max};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_wdata <= vals[i];
      sb.write_reg(idx[i], vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // one frame: preamble rise and fall, start gap, start bit, 24 data bits;
  // a zero bit is a short width plus a skipped short edge, a one a long width
  // ------------------------------------------------------------------------
  task automatic send_frame(frame_flaw_t flaw);
    logic [10:0] id;
    logic [5:0]  cmd;
    logic [16:0] body;
    logic [7:0]  c;
    logic [23:0] bits;
    logic [31:0] t;
    logic        lvl;
    int unsigned cut_at;
    case ($urandom_range(0, 7))
      0: begin id = '0; cmd = '0; end
      1: begin id = '1; cmd = '1; end
      default: begin id = 11'($urandom()); cmd = 6'($urandom()); end
    endcase
    // seal the frame with its 7-bit crc over id and command
    body = {id, cmd};
    c = '0;
    for (int i = 16; i >= 0; i--) begin
      if (c[1] ^ body[i]) c = ((c ^ CRC_POLY) >> 1) | CRC_TOP;
      else c = c >> 1;
    end
    bits   = {body, c[7:1]};
    cut_at = $urandom_range(0, 23);
    if (flaw == FL_CRC) bits[cut_at] = ~bits[cut_at];

    // start at or after any back-off deadline
    if (sb.backing_off) begin
      if ($urandom_range(0, 3) == 0) send_edge(sb.deadline - $urandom_range(1, 2000), 1'b1);
      t = sb.deadline + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 500));
    end else if ($urandom_range(0, 9) == 0) begin
      // frame runs across the wrap of the tick counter
      t = 32'hFFFF_FFFF - $urandom_range(0, 400);
    end else begin
      t = sb.last_time + $urandom_range(1, 400);
    end

    // wrong polarity is ignored in the preamble phases
    if (flaw == FL_POLARITY) send_edge(t - 1, 1'b0);
    send_edge(t, 1'b1);
    if (flaw == FL_POLARITY) send_edge(t + 2, 1'b1);
    if (flaw == FL_BAD_PREAMBLE)
      t = t + miss_width(sb.cfg.preamble_min, sb.cfg.preamble_max);
    else
      t = t + hit_width(sb.cfg.preamble_min, sb.cfg.preamble_max);
    send_edge(t, 1'b0);
    if (flaw == FL_BAD_PREAMBLE) return;

    if (flaw == FL_BAD_GAP) begin
      t = t + miss_width(sb.cfg.gap_min, sb.cfg.gap_max);
      send_edge(t, 1'b1);
    end
    t = t + hit_width(sb.cfg.gap_min, sb.cfg.gap_max);
    send_edge(t, 1'b1);
    // start bit: any width
    t = t + $urandom_range(0, 30);
    send_edge(t, 1'b0);

    lvl = 1'b1;
    for (int i = 23; i >= 0; i--) begin
      if (flaw == FL_CUT && i == cut_at) return;
      if (flaw == FL_STRAY && i == cut_at) begin
        t = t + miss_width(sb.cfg.one_min, sb.cfg.one_max);
        send_edge(t, lvl);
        lvl = ~lvl;
      end
      if (bits[i]) begin
        t = t + hit_width(sb.cfg.one_min, sb.cfg.one_max);
        send_edge(t, lvl);
        lvl = ~lvl;
      end else begin
        t = t + hit_width(sb.cfg.zero_min, sb.cfg.zero_max);
        send_edge(t, lvl);
        lvl = ~lvl;
        t = t + hit_width(sb.cfg.zero_min, sb.cfg.zero_max);
        send_edge(t, lvl);
        lvl = ~lvl;
      end
    end
  endtask

  // random edges: anywhere on the counter, just behind or just after the last
  task automatic send_noise(int unsigned n);
    logic [31:0] t;
    for (int unsigned k = 0; k < n; k++) begin
      case ($urandom_range(0, 3))
        0: t = $urandom();
        1: t = sb.last_time - $urandom_range(0, 300);
        default: t = sb.last_time + $urandom_range(0, 300);
      endcase
      send_edge(t, 1'($urandom_range(0, 1)));
    end
  endtask

  // mostly clean frames, the rest damaged frames and noise
  task automatic run_mix(int unsigned n);
    int unsigned target;
    int unsigned r;
    target = sb.n_live + n;
    while (sb.n_live < target) begin
      steady = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      if (r < 58)      send_frame(FL_CLEAN);
      else if (r < 68) send_frame(FL_CRC);
      else if (r < 77) send_frame(FL_BAD_PREAMBLE);
      else if (r < 83) send_frame(FL_BAD_GAP);
      else if (r < 88) send_frame(FL_STRAY);
      else if (r < 92) send_frame(FL_CUT);
      else if (r < 95) send_frame(FL_POLARITY);
      else             send_noise($urandom_range(1, 6));
    end
    steady = 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // result side: random tready, one long hold-off on request
  // ------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        sb.check_report(m_tuser, m_tdata[10:0], m_tdata[16:11]);
        stall = pick_gap();
      end
      @(negedge clk);
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall != 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------------
  initial begin : stimulus
    cfg_t        c;
    logic [31:0] t;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, reset register values
    send_edge(32'd100, 1'b0);                    // falling edge while waiting for rise
    send_edge(32'd1000, 1'b1);                   // preamble rise
    send_edge(32'd1010, 1'b1);                   // second rise ignored
    send_edge(32'd1200, 1'b0);                   // width at preamble_max: rejected
    send_edge(32'd1200 + SHORT_BACKOFF - 1, 1'b1);   // one tick short of the deadline
    t = 32'd1200 + SHORT_BACKOFF;
    send_edge(t, 1'b1);                          // exactly at the deadline
    send_edge(t + 49, 1'b0);                     // width at preamble_min: rejected
    // four more rejects bring the error count to six
    for (int k = 0; k < 4; k++) begin
      t = sb.deadline;
      send_edge(t, 1'b1);
      send_edge(t + 10, 1'b0);
    end
    send_edge(sb.deadline, 1'b1);                // error limit back-off
    t = sb.deadline;
    send_edge(t, 1'b1);
    t = t + 199;  send_edge(t, 1'b0);            // preamble just inside
    t = t + 45;   send_edge(t, 1'b1);            // gap at gap_max
    t = t + 41;   send_edge(t, 1'b0);            // gap at gap_min
    t = t + 42;   send_edge(t, 1'b1);            // gap inside
    t = t + 7;    send_edge(t, 1'b0);            // start bit
    t = t + 11;   send_edge(t, 1'b1);            // width at zero_max
    t = t + 13;   send_edge(t, 1'b0);            // width at one_min
    t = t + 6;    send_edge(t, 1'b1);            // zero bit
    t = t + 10;   send_edge(t, 1'b0);            // skipped edge
    t = t + 21;   send_edge(t, 1'b1);            // one bit

    // random part at reset values, with one long receiver hold-off
    hold_req = 1'b1;
    run_mix(500);
    settle();

    // random but sensible windows
    c.preamble_min = 8'($urandom_range(20, 120));
    c.preamble_max = 8'(c.preamble_min + $urandom_range(2, 100));
    c.gap_min      = 8'($urandom_range(25, 60));
    c.gap_max      = 8'(c.gap_min + $urandom_range(2, 12));
    c.zero_min     = 8'($urandom_range(0, 6));
    c.zero_max     = 8'(c.zero_min + $urandom_range(2, 8));
    c.one_min      = 8'(c.zero_max + $urandom_range(0, 4));
    c.one_max      = 8'(c.one_min + $urandom_range(2, 20));
    load_cfg(c);
    run_mix(350);
    settle();

    // widest windows: every width from 1 to 254 is a zero bit
    load_cfg('{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255});
    run_mix(250);
    settle();

    // empty windows: every preamble is rejected
    load_cfg('{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0});
    run_mix(200);
    settle();

    // single-value windows at both ends of the range
    load_cfg('{8'd253, 8'd255, 8'd0, 8'd2, 8'd0, 8'd2, 8'd2, 8'd4});
    run_mix(300);
    settle();

    // back to the power-on values
    load_cfg('{8'd49, 8'd200, 8'd41, 8'd45, 8'd5, 8'd11, 8'd13, 8'd22});
    run_mix(350);
    settle();

    $display("%0d edge words sent (%0d counted), %0d results checked over six settings",
             sb.n_edges, sb.n_live, sb.n_reports);
    $display("results by status: ok %0d, crc %0d, preamble %0d, error limit %0d; %0d mismatches",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d results still expected", sb.pending());
    $display("tb_top failed");
    $finish;
  end

endmodule
